>>> rtl/typint_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Type intern table package
// Shared field widths, stream widths and controller/datapath interface types.
// ----------------------------------------------------------------------------
package typint_pkg;

    localparam int KIND_W         = 1;
    localparam int COUNT_W        = 4;
    localparam int ARG_W          = 8;
    localparam int ARG_FIELDS     = 8;
    localparam int INDEX_W        = 8;
    localparam int PRESET_ENTRIES = 3;

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 8;
    localparam int M_TUSER_W = 2;

    localparam int TUSER_INSERTED = 0;
    localparam int TUSER_FULL     = 1;

    typedef struct packed {
        logic load;
        logic scan;
        logic res_hit;
        logic res_insert;
        logic res_full;
    } typint_cmd_t;

    typedef struct packed {
        logic hit;
        logic exhausted;
        logic full;
    } typint_status_t;

endpackage

>>> rtl/typint_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Type intern table controller
// Sequences request capture, the entry scan, the resolution and result handoff.
// ----------------------------------------------------------------------------
module typint_ctrl (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    input  typint_pkg::typint_status_t status,
    output typint_pkg::typint_cmd_t    cmd
);
    import typint_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_DONE   = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                priority if (status.hit) begin
                    cmd.res_hit = 1'b1;
                    state_next  = ST_DONE;
                end else if (status.exhausted && status.full) begin
                    cmd.res_full = 1'b1;
                    state_next   = ST_DONE;
                end else if (status.exhausted) begin
                    cmd.res_insert = 1'b1;
                    state_next     = ST_DONE;
                end else begin
                    cmd.scan = 1'b1;
                end
            end
            ST_DONE: begin
                if (m_axis_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_DONE);

endmodule

>>> rtl/typint_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Type intern table datapath
// Request register, entry memory, scan pointer, entry compare and result register.
// ----------------------------------------------------------------------------
module typint_dp #(
    parameter int MAX_TYPES = 256,
    parameter int MAX_ARGS  = 8
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_kind,
    input  logic [typint_pkg::S_TDATA_W-1:0]      s_data,
    input  typint_pkg::typint_cmd_t               cmd,
    output typint_pkg::typint_status_t            status,
    output logic [typint_pkg::INDEX_W-1:0]        out_index,
    output logic                                  out_inserted,
    output logic                                  out_full
);
    import typint_pkg::*;

    localparam int AW     = $clog2(MAX_TYPES);
    localparam int PW     = AW + 1;
    localparam int ARGS_W = MAX_ARGS * ARG_W;
    localparam int ENT_W  = ARGS_W + COUNT_W + KIND_W;

    logic                rec_kind_reg;
    logic [COUNT_W-1:0]  rec_count_reg;
    logic [ARGS_W-1:0]   rec_args_reg;

    logic [ENT_W-1:0]    mem [MAX_TYPES];
    logic [ENT_W-1:0]    mem_q_reg;
    logic                preset_reg;
    logic [1:0]          preset_idx_reg;

    logic [PW-1:0]       fill_reg;
    logic [PW-1:0]       rd_ptr_reg;
    logic [PW-1:0]       pend_idx_reg;
    logic                pend_valid_reg;
    logic                pend_valid_next;

    logic [INDEX_W-1:0]  out_index_reg;
    logic                out_inserted_reg;
    logic                out_full_reg;

    logic                issue;
    logic                ent_kind;
    logic [COUNT_W-1:0]  ent_count;
    logic [ARGS_W-1:0]   ent_args;
    logic                args_eq;

    assign issue           = cmd.scan && (rd_ptr_reg != fill_reg);
    assign pend_valid_next = issue;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            rec_kind_reg  <= s_kind;
            rec_count_reg <= s_data[COUNT_W-1:0];
            rec_args_reg  <= s_data[COUNT_W +: ARGS_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_insert) begin
            mem[fill_reg[AW-1:0]] <= {rec_args_reg, rec_count_reg, rec_kind_reg};
        end
        mem_q_reg      <= mem[rd_ptr_reg[AW-1:0]];
        preset_reg     <= (rd_ptr_reg < PW'(PRESET_ENTRIES));
        preset_idx_reg <= rd_ptr_reg[1:0];
        if (issue) begin
            pend_idx_reg <= rd_ptr_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg       <= PW'(PRESET_ENTRIES);
            rd_ptr_reg     <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            pend_valid_reg <= pend_valid_next;
            if (cmd.load) begin
                rd_ptr_reg <= '0;
            end else if (issue) begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            if (cmd.res_insert) begin
                fill_reg <= fill_reg + PW'(1);
            end
        end
    end

    // The preset atomic entries live in logic, so the memory needs no init.
    always_comb begin
        if (preset_reg) begin
            ent_kind  = 1'b0;
            ent_count = COUNT_W'(1);
            ent_args  = ARGS_W'(preset_idx_reg);
        end else begin
            ent_kind  = mem_q_reg[0];
            ent_count = mem_q_reg[KIND_W +: COUNT_W];
            ent_args  = mem_q_reg[KIND_W + COUNT_W +: ARGS_W];
        end
    end

    always_comb begin
        args_eq = 1'b1;
        for (int i = 0; i < MAX_ARGS; i++) begin
            if ((COUNT_W'(i) < rec_count_reg) &&
                (ent_args[i*ARG_W +: ARG_W] != rec_args_reg[i*ARG_W +: ARG_W])) begin
                args_eq = 1'b0;
            end
        end
    end

    assign status.hit       = pend_valid_reg && (ent_kind == rec_kind_reg) &&
                              (ent_count == rec_count_reg) && args_eq;
    assign status.exhausted = (rd_ptr_reg == fill_reg) && !pend_valid_reg;
    assign status.full      = (fill_reg == PW'(MAX_TYPES));

    always_ff @(posedge aclk) begin
        if (cmd.res_hit) begin
            out_index_reg    <= INDEX_W'(pend_idx_reg);
            out_inserted_reg <= 1'b0;
            out_full_reg     <= 1'b0;
        end else if (cmd.res_insert) begin
            out_index_reg    <= INDEX_W'(fill_reg);
            out_inserted_reg <= 1'b1;
            out_full_reg     <= 1'b0;
        end else if (cmd.res_full) begin
            out_index_reg    <= '0;
            out_inserted_reg <= 1'b0;
            out_full_reg     <= 1'b1;
        end
    end

    assign out_index    = out_index_reg;
    assign out_inserted = out_inserted_reg;
    assign out_full     = out_full_reg;

endmodule

>>> rtl/type_intern_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Type intern table
// Find-or-insert table of type records with a linear scan of stored entries.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                              | tuser
//  s_axis  | in  | arg_count, arg_0 .. arg_7, pad     | constructor_kind
//  m_axis  | out | type_index                         | was_inserted, table_full
//
// A request is resolved by a scan from entry 0 that stops at the first matching entry;
// a miss scans all fill_level entries. The scan goes through the single read
// port of the entry memory, one entry per cycle, and the read data is registered.
// Reset restores three atomic entries; they are held in logic, so there is
// no clearing pass. One request is in flight at a time: s_axis_tready stays
// low until the result has been taken on m_axis.
module type_intern_table #(
    parameter int MAX_TYPES = 256,
    parameter int MAX_ARGS  = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [3:0] arg_count, [11:4] arg_0, ... [67:60] arg_7, [71:68] zero
    input  logic [typint_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // [0] constructor_kind
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [7:0] type_index
    output logic [typint_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // [0] was_inserted, [1] table_full
    output logic [typint_pkg::M_TUSER_W-1:0]    m_axis_tuser
);
    import typint_pkg::*;

    typint_cmd_t    cmd;
    typint_status_t status;
    logic [INDEX_W-1:0] out_index;
    logic               out_inserted;
    logic               out_full;

    typint_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    typint_dp #(
        .MAX_TYPES (MAX_TYPES),
        .MAX_ARGS  (MAX_ARGS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_kind       (s_axis_tuser),
        .s_data       (s_axis_tdata),
        .cmd          (cmd),
        .status       (status),
        .out_index    (out_index),
        .out_inserted (out_inserted),
        .out_full     (out_full)
    );

    assign m_axis_tdata                 = out_index;
    assign m_axis_tuser[TUSER_INSERTED] = out_inserted;
    assign m_axis_tuser[TUSER_FULL]     = out_full;

endmodule

>>> rtl/typint_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Type intern table checker
// Port-level properties of the type intern table, bound to the top level.
// ----------------------------------------------------------------------------
module typint_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [typint_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    input logic [typint_pkg::M_TUSER_W-1:0]    m_axis_tuser
);
    import typint_pkg::*;

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while a result is pending");

    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid)
        else $error("result appeared in the cycle after a request");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !(m_axis_tuser[TUSER_INSERTED] && m_axis_tuser[TUSER_FULL]))
        else $error("inserted and full flagged together");

    a_full_index_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser[TUSER_FULL]) |-> (m_axis_tdata == '0))
        else $error("full result carries a nonzero index");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind type_intern_table typint_checker u_typint_checker (.*);

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Type intern table testbench
// Sends type records on the input stream and keeps its own copy of the intern
// table to predict each result: the index of the first equal stored entry, or
// the index of a newly appended entry, or the full flag once the table is
// exhausted. Directed records cover the preset entries, field extremes,
// ignored arguments and counts above the argument limit. Random records mix
// repeats of stored entries, near misses, new records and noise, and the run
// fills the table and keeps going past the full point. Both stream sides
// idle in random bursts except in the final part.
// ----------------------------------------------------------------------------
module tb_top;
    import typint_pkg::*;

    localparam int TABLE_DEPTH  = 256;
    localparam int DRAIN_CYCLES = TABLE_DEPTH + 40;

    typedef struct packed {
        logic                             kind;
        logic [COUNT_W-1:0]               count;
        logic [ARG_FIELDS-1:0][ARG_W-1:0] args;
    } type_rec_t;

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic               inserted;
        logic               full;
    } intern_result_t;

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // [3:0] arg_count, [11:4] arg_0, ... [67:60] arg_7, [71:68] zero
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    // [0] constructor_kind
    logic                 s_axis_tuser  = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // [7:0] type_index
    logic [M_TDATA_W-1:0] m_axis_tdata;
    // [0] was_inserted, [1] table_full
    logic [M_TUSER_W-1:0] m_axis_tuser;

    logic                             tbl_kind  [TABLE_DEPTH];
    logic [COUNT_W-1:0]               tbl_count [TABLE_DEPTH];
    logic [ARG_FIELDS-1:0][ARG_W-1:0] tbl_args  [TABLE_DEPTH];
    int                               tbl_fill;

    intern_result_t expected_results[$];
    int             mismatch_count = 0;
    bit             idle_enable    = 1'b1;
    int             ready_stall    = 0;

    type_intern_table #(
        .MAX_TYPES(TABLE_DEPTH),
        .MAX_ARGS (ARG_FIELDS)
    ) u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    task automatic reset_table();
        for (int e = 0; e < PRESET_ENTRIES; e++) begin
            tbl_kind[e]  = 1'b0;
            tbl_count[e] = COUNT_W'(1);
            tbl_args[e]  = '0;
            tbl_args[e][0] = ARG_W'(e);
        end
        tbl_fill = PRESET_ENTRIES;
    endtask

    function automatic intern_result_t intern_lookup(input type_rec_t rec);
        intern_result_t res;
        int             n;
        bit             same;
        res = '0;
        n = (rec.count > ARG_FIELDS) ? ARG_FIELDS : rec.count;
        for (int e = 0; e < tbl_fill; e++) begin
            same = (tbl_kind[e] == rec.kind) && (tbl_count[e] == rec.count);
            for (int i = 0; i < n; i++) begin
                if (tbl_args[e][i] != rec.args[i]) same = 1'b0;
            end
            if (same) begin
                res.index = INDEX_W'(e);
                return res;
            end
        end
        if (tbl_fill >= TABLE_DEPTH) begin
            res.full = 1'b1;
            return res;
        end
        tbl_kind[tbl_fill]  = rec.kind;
        tbl_count[tbl_fill] = rec.count;
        tbl_args[tbl_fill]  = rec.args;
        res.index    = INDEX_W'(tbl_fill);
        res.inserted = 1'b1;
        tbl_fill++;
        return res;
    endfunction

    function automatic type_rec_t make_record(input logic kind, input int count,
                                              input logic [ARG_FIELDS*ARG_W-1:0] args);
        type_rec_t rec;
        rec.kind  = kind;
        rec.count = COUNT_W'(count);
        rec.args  = args;
        return rec;
    endfunction

    function automatic type_rec_t random_record(input int max_count);
        type_rec_t rec;
        rec.kind  = 1'($urandom_range(0, 1));
        rec.count = COUNT_W'($urandom_range(0, max_count));
        rec.args  = {$urandom, $urandom};
        return rec;
    endfunction

    // Copy of a stored entry with fresh values in the arguments it ignores.
    function automatic type_rec_t stored_record(input int e);
        type_rec_t                        rec;
        logic [ARG_FIELDS-1:0][ARG_W-1:0] junk;
        rec.kind  = tbl_kind[e];
        rec.count = tbl_count[e];
        rec.args  = tbl_args[e];
        junk = {$urandom, $urandom};
        for (int i = 0; i < ARG_FIELDS; i++) begin
            if (i >= rec.count) rec.args[i] = junk[i];
        end
        return rec;
    endfunction

    function automatic type_rec_t draw_record();
        type_rec_t rec;
        int        pick;
        int        n;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            rec = stored_record($urandom_range(0, tbl_fill - 1));
        end else if (pick < 55) begin
            rec = stored_record($urandom_range(0, tbl_fill - 1));
            n = (rec.count > ARG_FIELDS) ? ARG_FIELDS : rec.count;
            case ($urandom_range(0, 2))
                0: rec.kind = ~rec.kind;
                1: rec.count = rec.count ^ COUNT_W'($urandom_range(1, 15));
                default: begin
                    if (n > 0)
                        rec.args[$urandom_range(0, n - 1)] ^= ARG_W'($urandom_range(1, 255));
                    else
                        rec.kind = ~rec.kind;
                end
            endcase
        end else if (pick < 65) begin
            rec = random_record(15);
        end else begin
            rec = random_record(ARG_FIELDS);
        end
        return rec;
    endfunction

    task automatic send_record(input type_rec_t rec);
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= S_TDATA_W'({rec.args, rec.count});
        s_axis_tuser  <= rec.kind;
        do @(posedge aclk); while (!s_axis_tready);
        expected_results.push_back(intern_lookup(rec));
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        intern_result_t got;
        intern_result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata, m_axis_tuser[TUSER_INSERTED], m_axis_tuser[TUSER_FULL]};
            if (expected_results.size() == 0) begin
                if (mismatch_count < 10)
                    $display("unexpected result: index %0d inserted %0b full %0b",
                             got.index, got.inserted, got.full);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                if (got.index !== want.index || got.inserted !== want.inserted ||
                    got.full !== want.full) begin
                    if (mismatch_count < 10)
                        $display("mismatch: expected index %0d inserted %0b full %0b, %s",
                                 want.index, want.inserted, want.full,
                                 $sformatf("got index %0d inserted %0b full %0b",
                                           got.index, got.inserted, got.full));
                    mismatch_count++;
                end
            end
        end
        if (ready_stall > 0) begin
            m_axis_tready <= 1'b0;
            ready_stall--;
        end else if (idle_enable && $urandom_range(0, 4) == 0) begin
            m_axis_tready <= 1'b0;
            ready_stall = $urandom_range(0, 13);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic test_preset_entries();
        send_record(make_record(1'b0, 1, {56'hDEAD_BEEF_1234_56, 8'd0}));
        send_record(make_record(1'b0, 1, {56'hFF_FFFF_FFFF_FFFF, 8'd1}));
        send_record(make_record(1'b0, 1, {56'h00_0000_0000_0000, 8'd2}));
        send_record(make_record(1'b0, 1, 64'd3));
        send_record(make_record(1'b1, 1, 64'd0));
        send_record(make_record(1'b0, 0, '1));
        send_record(make_record(1'b0, 0, '0));
    endtask

    task automatic test_field_extremes();
        send_record(make_record(1'b1, ARG_FIELDS, '1));
        send_record(make_record(1'b1, ARG_FIELDS, '0));
        send_record(make_record(1'b1, ARG_FIELDS, '1));
        send_record(make_record(1'b0, ARG_FIELDS, '1));
        send_record(make_record(1'b1, 0, '0));
        send_record(make_record(1'b1, 0, '1));
    endtask

    // The count is compared as given even above the number of argument fields.
    task automatic test_count_above_limit();
        send_record(make_record(1'b1, 15, '1));
        send_record(make_record(1'b1, 15, '1));
        send_record(make_record(1'b1, 15, 64'h5555_5555_5555_5555));
        send_record(make_record(1'b1, 9, '1));
        send_record(make_record(1'b0, 9, 64'hAAAA_AAAA_AAAA_AAAA));
    endtask

    task automatic test_ignored_args();
        send_record(make_record(1'b1, 2, 64'h0000_0000_0000_0605));
        send_record(make_record(1'b1, 2, 64'hFFFF_FFFF_FFFF_0605));
        send_record(make_record(1'b1, 2, 64'h0000_0000_0000_0705));
        send_record(make_record(1'b1, 3, 64'h0000_0000_0000_0605));
    endtask

    task automatic test_random_mix();
        repeat (1200) send_record(draw_record());
    endtask

    task automatic test_table_full();
        while (tbl_fill < TABLE_DEPTH) send_record(random_record(ARG_FIELDS));
        repeat (5) send_record(random_record(15));
        send_record(stored_record(TABLE_DEPTH - 1));
        send_record(stored_record(0));
        send_record(make_record(1'b1, ARG_FIELDS, 64'h0123_4567_89AB_CDEF));
    endtask

    task automatic test_after_full();
        idle_enable = 1'b0;
        repeat (250) send_record(draw_record());
    endtask

    initial begin
        reset_table();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_preset_entries();
        test_field_extremes();
        test_count_above_limit();
        test_ignored_args();
        wait_for_results();
        test_random_mix();
        wait_for_results();
        test_table_full();
        test_after_full();
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> files.f
rtl/typint_pkg.sv
rtl/typint_ctrl.sv
rtl/typint_dp.sv
rtl/type_intern_table.sv
rtl/typint_checker.sv
tb/tb_top.sv
